// ----- src/ecgr_pkg.sv -----
// ----------------------------------------------------------------------------
// ecgr_pkg: shared types, constants and arithmetic for the R-peak detector
// Holds the controller states, the command/status bundles, the reset levels
// and the fixed-point averaging helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecgr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int RR_W     = 16;

   localparam int PEAK_DEPTH_DEF = 128;
   localparam int AVG_LEN_DEF    = 8;

   // Reset levels
   localparam logic signed [SAMPLE_W-1:0] SIGNAL_RST = 16'sd4500;
   localparam logic signed [SAMPLE_W-1:0] NOISE_RST  = 16'sd2000;
   localparam logic signed [SAMPLE_W-1:0] TH_MAIN_RST = 16'sd2300;
   localparam logic signed [SAMPLE_W-1:0] TH_SRCH_RST = 16'sd1300;
   localparam logic [RR_W-1:0] RR_AVG_RST  = 16'd160;
   localparam logic [RR_W-1:0] RR_LAST_RST = 16'd160;
   localparam logic [RR_W-1:0] RR_LOW_RST  = 16'd120;
   localparam logic [RR_W-1:0] RR_HIGH_RST = 16'd246;
   localparam logic [RR_W-1:0] RR_MISS_RST = 16'd352;
   localparam logic [RR_W-1:0] RR_MAX      = 16'hFFFF;

   // Q8 ratios 0.92, 1.16, 1.66
   localparam logic [8:0] Q8_LOW  = 9'd236;
   localparam logic [8:0] Q8_HIGH = 9'd297;
   localparam logic [8:0] Q8_MISS = 9'd425;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_SCAN_DECIDE,
      ST_REGULAR,
      ST_LATE,
      ST_NOISE,
      ST_LIM_LOW,
      ST_LIM_HIGH,
      ST_LIM_MISS,
      ST_THRESH,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      LIM_LOW,
      LIM_HIGH,
      LIM_MISS
   } lim_sel_type;

   typedef struct packed {
      logic        accept;
      logic        classify;
      logic        scan_step;
      logic        regular_upd;
      logic        late_upd;
      logic        noise_upd;
      logic        lim_write;
      lim_sel_type lim_sel;
      logic        thresh_write;
      logic        finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_peak;
      logic above_main;
      logic in_limits;
      logic below_miss;
      logic scan_last;
      logic hit;
   } ctrl_status_type;

   // (peak + 7*level) / 8, truncating toward zero
   function automatic logic signed [SAMPLE_W-1:0] avg_eighth(
      input logic signed [SAMPLE_W-1:0] pk,
      input logic signed [SAMPLE_W-1:0] lvl
   );
      logic signed [SAMPLE_W+3:0] p;
      logic signed [SAMPLE_W+3:0] l;
      logic signed [SAMPLE_W+3:0] v;
      p = (SAMPLE_W+4)'(pk);
      l = (SAMPLE_W+4)'(lvl);
      v = p + (l <<< 3) - l;
      if (v < 0) begin
         v = v + (SAMPLE_W+4)'(7);
      end
      return v[SAMPLE_W+2:3];
   endfunction

   // (peak + 3*level) / 4, truncating toward zero
   function automatic logic signed [SAMPLE_W-1:0] avg_quarter(
      input logic signed [SAMPLE_W-1:0] pk,
      input logic signed [SAMPLE_W-1:0] lvl
   );
      logic signed [SAMPLE_W+2:0] p;
      logic signed [SAMPLE_W+2:0] l;
      logic signed [SAMPLE_W+2:0] v;
      p = (SAMPLE_W+3)'(pk);
      l = (SAMPLE_W+3)'(lvl);
      v = p + (l <<< 1) + l;
      if (v < 0) begin
         v = v + (SAMPLE_W+3)'(3);
      end
      return v[SAMPLE_W+1:2];
   endfunction

endpackage

// ----- src/ecgr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ecgr_ctrl: sequencing controller
// Steps each word through classify, search back, level, limit and threshold
// updates, and owns the handshake and the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecgr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ecgr_pkg::ctrl_cmd_type    cmd,
   input  ecgr_pkg::ctrl_status_type sts
);

   ecgr_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ecgr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.lim_sel  = ecgr_pkg::LIM_LOW;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ecgr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ecgr_pkg::ST_CLASSIFY;
            end
         end
         ecgr_pkg::ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            if (!sts.is_peak) begin
               state_in = ecgr_pkg::ST_FINISH;
            end else if (!sts.above_main) begin
               state_in = ecgr_pkg::ST_NOISE;
            end else if (sts.in_limits) begin
               state_in = ecgr_pkg::ST_REGULAR;
            end else if (sts.below_miss) begin
               state_in = ecgr_pkg::ST_SCAN;
            end else begin
               state_in = ecgr_pkg::ST_FINISH;
            end
         end
         ecgr_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ecgr_pkg::ST_SCAN_WAIT;
            end
         end
         ecgr_pkg::ST_SCAN_WAIT: begin
            state_in = ecgr_pkg::ST_SCAN_DECIDE;
         end
         ecgr_pkg::ST_SCAN_DECIDE: begin
            state_in = sts.hit ? ecgr_pkg::ST_LATE : ecgr_pkg::ST_FINISH;
         end
         ecgr_pkg::ST_REGULAR: begin
            cmd.regular_upd = 1'b1;
            state_in        = ecgr_pkg::ST_LIM_LOW;
         end
         ecgr_pkg::ST_LATE: begin
            cmd.late_upd = 1'b1;
            state_in     = ecgr_pkg::ST_LIM_LOW;
         end
         ecgr_pkg::ST_NOISE: begin
            cmd.noise_upd = 1'b1;
            state_in      = ecgr_pkg::ST_THRESH;
         end
         ecgr_pkg::ST_LIM_LOW: begin
            cmd.lim_write = 1'b1;
            cmd.lim_sel   = ecgr_pkg::LIM_LOW;
            state_in      = ecgr_pkg::ST_LIM_HIGH;
         end
         ecgr_pkg::ST_LIM_HIGH: begin
            cmd.lim_write = 1'b1;
            cmd.lim_sel   = ecgr_pkg::LIM_HIGH;
            state_in      = ecgr_pkg::ST_LIM_MISS;
         end
         ecgr_pkg::ST_LIM_MISS: begin
            cmd.lim_write = 1'b1;
            cmd.lim_sel   = ecgr_pkg::LIM_MISS;
            state_in      = ecgr_pkg::ST_THRESH;
         end
         ecgr_pkg::ST_THRESH: begin
            cmd.thresh_write = 1'b1;
            state_in         = ecgr_pkg::ST_FINISH;
         end
         ecgr_pkg::ST_FINISH: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ecgr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ecgr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/ecgr_datapath.sv -----
// ----------------------------------------------------------------------------
// ecgr_datapath: window, peak ring and detector levels
// Finds local peaks, keeps the peak ring with its valid bits, scans it one
// entry a cycle, and updates levels, RR average, limits and thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecgr_datapath #(
   parameter int PEAK_DEPTH = ecgr_pkg::PEAK_DEPTH_DEF,
   parameter int AVG_LEN    = ecgr_pkg::AVG_LEN_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [ecgr_pkg::SAMPLE_W-1:0]  req_sample,
   input  ecgr_pkg::ctrl_cmd_type                 cmd,
   output ecgr_pkg::ctrl_status_type              sts,
   output logic                                  rsp_detected,
   output logic                                  rsp_late_accept,
   output logic signed [ecgr_pkg::SAMPLE_W-1:0]  rsp_peak_value,
   output logic [ecgr_pkg::RR_W-1:0]             rsp_rr_interval
);

   localparam int IDX_W = $clog2(PEAK_DEPTH);
   localparam int SW    = ecgr_pkg::SAMPLE_W;
   localparam int RW    = ecgr_pkg::RR_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PEAK_DEPTH - 1);

   // window and current item
   logic signed [SW-1:0] win1_ff, win2_ff;
   logic signed [SW-1:0] pk_ff;
   logic                 is_peak_ff;
   logic                 peak_now;
   logic [RW-1:0]        rr_ff;
   logic                 det_ff, late_ff;

   // detector state
   logic [RW-1:0]        interval_ff;
   logic signed [SW-1:0] signal_ff, noise_ff, th_main_ff, th_srch_ff;
   logic [RW-1:0]        rr_avg_ff, rr_last_ff, rr_low_ff, rr_high_ff, rr_miss_ff;

   // peak ring
   logic signed [SW-1:0] ring_mem [PEAK_DEPTH];
   logic [PEAK_DEPTH-1:0] ring_valid_ff;
   logic [IDX_W-1:0]     wr_idx_ff;
   logic [IDX_W-1:0]     scan_idx_ff;
   logic signed [SW-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic                 rd_pending_ff;
   logic                 hit_ff;
   logic signed [SW-1:0] rd_entry;

   // arithmetic
   logic signed [RW+1:0] avg_sum;
   logic [RW-1:0]        avg_new;
   logic [8:0]           ratio;
   logic [RW+8:0]        prod;
   logic [RW-1:0]        lim_new;
   logic signed [SW+1:0] th_sum;
   logic signed [SW-1:0] th_main_new, th_main_adj, th_srch_new;

   assign peak_now = (win2_ff < win1_ff) && (win1_ff > req_sample);
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

   // status toward the controller
   assign sts.is_peak    = is_peak_ff;
   assign sts.above_main = pk_ff > th_main_ff;
   assign sts.in_limits  = (rr_low_ff < interval_ff) && (interval_ff < rr_high_ff);
   assign sts.below_miss = interval_ff < rr_miss_ff;
   assign sts.scan_last  = scan_idx_ff == IDX_LAST;
   assign sts.hit        = hit_ff;

   // RR average with saturation
   always_comb begin
      avg_sum = (RW+2)'(rr_avg_ff) - (RW+2)'(RW'(rr_last_ff / AVG_LEN))
              + (RW+2)'(RW'(rr_ff / AVG_LEN));
      if (avg_sum < 0) begin
         avg_new = '0;
      end else if (avg_sum > (RW+2)'(ecgr_pkg::RR_MAX)) begin
         avg_new = ecgr_pkg::RR_MAX;
      end else begin
         avg_new = avg_sum[RW-1:0];
      end
   end

   // shared limit multiplier
   always_comb begin
      case (cmd.lim_sel)
         ecgr_pkg::LIM_HIGH: ratio = ecgr_pkg::Q8_HIGH;
         ecgr_pkg::LIM_MISS: ratio = ecgr_pkg::Q8_MISS;
         default:            ratio = ecgr_pkg::Q8_LOW;
      endcase
      prod = (RW+9)'(rr_avg_ff) * (RW+9)'(ratio);
      if (prod[RW+8:RW+8] != 1'b0 || prod[RW+7:8] > (RW)'(ecgr_pkg::RR_MAX)) begin
         lim_new = ecgr_pkg::RR_MAX;
      end else begin
         lim_new = prod[RW+7:8];
      end
   end

   // thresholds: (3*noise + signal)/4 and half of that, toward zero
   always_comb begin
      th_sum = (SW+2)'(noise_ff) + ((SW+2)'(noise_ff) <<< 1) + (SW+2)'(signal_ff);
      if (th_sum < 0) begin
         th_sum = th_sum + (SW+2)'(3);
      end
      th_main_new = th_sum[SW+1:2];
      th_main_adj = th_main_new + SW'(th_main_new < 0);
      th_srch_new = {th_main_adj[SW-1], th_main_adj[SW-1:1]};
   end

   // control and detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         win1_ff       <= '0;
         win2_ff       <= '0;
         is_peak_ff    <= 1'b0;
         det_ff        <= 1'b0;
         late_ff       <= 1'b0;
         interval_ff   <= '0;
         signal_ff     <= ecgr_pkg::SIGNAL_RST;
         noise_ff      <= ecgr_pkg::NOISE_RST;
         th_main_ff    <= ecgr_pkg::TH_MAIN_RST;
         th_srch_ff    <= ecgr_pkg::TH_SRCH_RST;
         rr_avg_ff     <= ecgr_pkg::RR_AVG_RST;
         rr_last_ff    <= ecgr_pkg::RR_LAST_RST;
         rr_low_ff     <= ecgr_pkg::RR_LOW_RST;
         rr_high_ff    <= ecgr_pkg::RR_HIGH_RST;
         rr_miss_ff    <= ecgr_pkg::RR_MISS_RST;
         ring_valid_ff <= '0;
         wr_idx_ff     <= '0;
         scan_idx_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         rd_pending_ff <= 1'b0;
         hit_ff        <= 1'b0;
      end else begin
         rd_pending_ff <= cmd.scan_step;
         // take the word, shift the window, mark the ring slot
         if (cmd.accept) begin
            win2_ff    <= win1_ff;
            win1_ff    <= req_sample;
            pk_ff      <= win1_ff;
            is_peak_ff <= peak_now;
            det_ff     <= 1'b0;
            late_ff    <= 1'b0;
            rr_ff      <= '0;
            if (peak_now) begin
               ring_valid_ff[wr_idx_ff] <= 1'b1;
            end
         end
         // take the interval at an above-threshold peak
         if (cmd.classify) begin
            scan_idx_ff <= '0;
            hit_ff      <= 1'b0;
            if (is_peak_ff && sts.above_main) begin
               rr_ff       <= interval_ff;
               interval_ff <= '0;
            end
         end
         // search back, one entry a cycle
         if (cmd.scan_step) begin
            rd_valid_ff <= ring_valid_ff[scan_idx_ff];
            if (scan_idx_ff != IDX_LAST) begin
               scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            end
         end
         if (rd_pending_ff && (rd_entry > th_srch_ff)) begin
            hit_ff <= 1'b1;
         end
         if (cmd.regular_upd) begin
            signal_ff  <= ecgr_pkg::avg_eighth(pk_ff, signal_ff);
            rr_avg_ff  <= avg_new;
            rr_last_ff <= rr_ff;
            det_ff     <= 1'b1;
            wr_idx_ff  <= (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + IDX_W'(1);
         end
         if (cmd.late_upd) begin
            signal_ff <= ecgr_pkg::avg_quarter(pk_ff, signal_ff);
            late_ff   <= 1'b1;
         end
         if (cmd.noise_upd) begin
            noise_ff <= ecgr_pkg::avg_eighth(pk_ff, noise_ff);
         end
         if (cmd.lim_write) begin
            case (cmd.lim_sel)
               ecgr_pkg::LIM_HIGH: rr_high_ff <= lim_new;
               ecgr_pkg::LIM_MISS: rr_miss_ff <= lim_new;
               default:            rr_low_ff  <= lim_new;
            endcase
         end
         if (cmd.thresh_write) begin
            th_main_ff <= th_main_new;
            th_srch_ff <= th_srch_new;
         end
         // close the word: advance ring slot and interval
         if (cmd.finish) begin
            if (is_peak_ff) begin
               wr_idx_ff <= (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + IDX_W'(1);
            end
            if (interval_ff != ecgr_pkg::RR_MAX) begin
               interval_ff <= interval_ff + RW'(1);
            end
         end
      end
   end

   // peak ring storage
   always_ff @(posedge clock) begin
      if (cmd.accept && peak_now) begin
         ring_mem[wr_idx_ff] <= win1_ff;
      end
      if (cmd.scan_step) begin
         rd_data_ff <= ring_mem[scan_idx_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_detected    <= det_ff;
         rsp_late_accept <= late_ff;
         rsp_peak_value  <= is_peak_ff ? pk_ff : '0;
         rsp_rr_interval <= (det_ff || late_ff) ? rr_ff : '0;
      end
   end

endmodule

// ----- src/ecg_r_peak_detector.sv -----
// A word with no peak, or with a peak past the miss limit, goes from classify
// to finish; a noise peak passes the noise update and threshold; a regular R
// peak the regular update, low, high and miss limit writes and threshold; the
// search back reads the ring one entry a cycle, then finishes (no hit) or runs
// the late update, limits and threshold. One word at a time: the next word is
// taken in idle after the previous result is registered, while it may still wait.
// ----------------------------------------------------------------------------
// ecg_r_peak_detector: R-peak detection top level
// Joins the sequencing controller and the detector datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecg_r_peak_detector #(
   parameter int PEAK_DEPTH = ecgr_pkg::PEAK_DEPTH_DEF,
   parameter int AVG_LEN    = ecgr_pkg::AVG_LEN_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [ecgr_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_detected,
   output logic                                  rsp_late_accept,
   output logic signed [ecgr_pkg::SAMPLE_W-1:0]  rsp_peak_value,
   output logic [ecgr_pkg::RR_W-1:0]             rsp_rr_interval
);

   ecgr_pkg::ctrl_cmd_type    cmd;
   ecgr_pkg::ctrl_status_type sts;

   ecgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ecgr_datapath #(
      .PEAK_DEPTH (PEAK_DEPTH),
      .AVG_LEN    (AVG_LEN)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_sample      (req_sample),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_detected    (rsp_detected),
      .rsp_late_accept (rsp_late_accept),
      .rsp_peak_value  (rsp_peak_value),
      .rsp_rr_interval (rsp_rr_interval)
   );

   // one word in flight: no back-to-back accepts
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word accepted while one is in flight");

   // a word is never both a regular and a late detection
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_detected && rsp_late_accept))
      else $error("regular and late detection set together");

   // the interval is reported only with a detection
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_detected && !rsp_late_accept) |-> (rsp_rr_interval == '0))
      else $error("interval reported without a detection");

endmodule

// ----- test/ecg_r_peak_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecg_r_peak_checker: scoreboard for the R-peak detector
// Watches the sample and result channels, runs its own Pan-Tompkins style
// beat classifier on every accepted sample and compares each result word
// field by field against the oldest predicted beat decision.
// ----------------------------------------------------------------------------

module ecg_r_peak_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [ecgr_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_detected,
   input  logic                                 rsp_late_accept,
   input  logic signed [ecgr_pkg::SAMPLE_W-1:0] rsp_peak_value,
   input  logic [ecgr_pkg::RR_W-1:0]            rsp_rr_interval,
   output int                                   fail_count,
   output int                                   beats_pending,
   output int                                   beat_count,
   output int                                   late_count,
   output int                                   noise_count
);

   localparam int SW       = ecgr_pkg::SAMPLE_W;
   localparam int RW       = ecgr_pkg::RR_W;
   localparam int RING_LEN = 128;
   localparam int AVG_DIV  = 8;

   typedef struct {
      logic                 det;
      logic                 late;
      logic signed [SW-1:0] pk;
      logic [RW-1:0]        rr;
   } beat_word_type;

   beat_word_type beat_queue[$];

   // classifier state
   int win [3];
   int win_pos;
   int ring [RING_LEN];
   int ring_wr;
   int interval;
   int sig_lvl, noise_lvl, th_main, th_srch;
   int rr_avg, rr_prev, rr_lo, rr_hi, rr_miss;

   function automatic int scale_ratio(input int avg, input int ratio);
      longint v;
      v = (longint'(avg) * ratio) >>> 8;
      return (v > 65535) ? 65535 : int'(v);
   endfunction

   task automatic clear_classifier();
      for (int i = 0; i < 3; i++) win[i] = 0;
      for (int i = 0; i < RING_LEN; i++) ring[i] = 0;
      win_pos = 0; ring_wr = 0; interval = 0;
      sig_lvl = ecgr_pkg::SIGNAL_RST; noise_lvl = ecgr_pkg::NOISE_RST;
      th_main = ecgr_pkg::TH_MAIN_RST; th_srch = ecgr_pkg::TH_SRCH_RST;
      rr_avg = ecgr_pkg::RR_AVG_RST; rr_prev = ecgr_pkg::RR_LAST_RST;
      rr_lo = ecgr_pkg::RR_LOW_RST; rr_hi = ecgr_pkg::RR_HIGH_RST;
      rr_miss = ecgr_pkg::RR_MISS_RST;
   endtask

   task automatic retune();
      rr_lo   = scale_ratio(rr_avg, ecgr_pkg::Q8_LOW);
      rr_hi   = scale_ratio(rr_avg, ecgr_pkg::Q8_HIGH);
      rr_miss = scale_ratio(rr_avg, ecgr_pkg::Q8_MISS);
   endtask

   task automatic classify_sample(input logic signed [SW-1:0] s,
                                  output beat_word_type w);
      int prv, mid, rr, a;
      logic hit;
      w.det = 0; w.late = 0; w.pk = '0; w.rr = '0;
      win[win_pos] = s;
      prv = win[(win_pos + 1) % 3];
      mid = win[(win_pos + 2) % 3];
      if (prv < mid && mid > int'(s)) begin
         w.pk = mid[SW-1:0];
         ring[ring_wr] = mid;
         if (mid > th_main) begin
            rr = interval;
            interval = 0;
            if (rr_lo < rr && rr < rr_hi) begin
               // regular beat: full update of levels and RR statistics
               sig_lvl = (mid + 7 * sig_lvl) / 8;
               a = rr_avg - rr_prev / AVG_DIV + rr / AVG_DIV;
               rr_avg = (a < 0) ? 0 : (a > 65535) ? 65535 : a;
               retune();
               th_main = (3 * noise_lvl + sig_lvl) / 4;
               th_srch = th_main / 2;
               rr_prev = rr;
               ring_wr = (ring_wr + 1) % RING_LEN;
               w.det = 1; w.rr = rr[RW-1:0];
               beat_count++;
            end else if (rr < rr_miss) begin
               // search back: any stored peak above the search threshold
               hit = 0;
               for (int i = 0; i < RING_LEN; i++) if (ring[i] > th_srch) hit = 1;
               if (hit) begin
                  sig_lvl = (mid + 3 * sig_lvl) / 4;
                  retune();
                  th_main = (3 * noise_lvl + sig_lvl) / 4;
                  th_srch = th_main / 2;
                  w.late = 1; w.rr = rr[RW-1:0];
                  late_count++;
               end
            end
         end else begin
            noise_lvl = (mid + 7 * noise_lvl) / 8;
            th_main = (3 * noise_lvl + sig_lvl) / 4;
            th_srch = th_main / 2;
            noise_count++;
         end
         ring_wr = (ring_wr + 1) % RING_LEN;
      end
      if (interval < 65535) interval++;
      win_pos = (win_pos + 1) % 3;
   endtask

   always @(posedge clock) begin
      beat_word_type w, e;
      if (reset) begin
         clear_classifier();
         beat_queue.delete();
         fail_count = 0; beat_count = 0; late_count = 0; noise_count = 0;
      end else begin
         // predict for an accepted sample word
         if (req_valid && req_ready) begin
            classify_sample(req_sample, w);
            beat_queue.push_back(w);
         end
         // compare an accepted result word
         if (rsp_valid && rsp_ready) begin
            if (beat_queue.size() == 0) begin
               $error("result word with no prediction pending");
               fail_count++;
            end else begin
               e = beat_queue.pop_front();
               if (rsp_detected !== e.det) begin
                  $error("detected: expected %0d, got %0d", e.det, rsp_detected);
                  fail_count++;
               end
               if (rsp_late_accept !== e.late) begin
                  $error("late_accept: expected %0d, got %0d", e.late, rsp_late_accept);
                  fail_count++;
               end
               if (rsp_peak_value !== e.pk) begin
                  $error("peak_value: expected %0d, got %0d", e.pk, rsp_peak_value);
                  fail_count++;
               end
               if (rsp_rr_interval !== e.rr) begin
                  $error("rr_interval: expected %0d, got %0d", e.rr, rsp_rr_interval);
                  fail_count++;
               end
            end
         end
      end
      beats_pending = beat_queue.size();
   end

endmodule

// ----- test/tb_ecg_r_peak_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ecg_r_peak_detector: stimulus and verdict for the R-peak detector
// Feeds directed corner samples, then synthetic ECG traces (baseline noise
// with spikes at random beat spacing), with random stalls on both channels,
// one long result hold-off and one drain pause; the checker does the scoring.
// ----------------------------------------------------------------------------

module tb_ecg_r_peak_detector;

   localparam int SW    = ecgr_pkg::SAMPLE_W;
   localparam int RW    = ecgr_pkg::RR_W;
   localparam int ITEMS = 700;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_ready;
   logic signed [SW-1:0] req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   logic                 rsp_detected;
   logic                 rsp_late_accept;
   logic signed [SW-1:0] rsp_peak_value;
   logic [RW-1:0]        rsp_rr_interval;

   int  fail_count, beats_pending, beat_count, late_count, noise_count;
   int  words_sent = 0;
   bit  quiet = 0;
   bit  hold_req = 0;
   bit  hold_started = 0;
   bit  drain_done = 0;

   always #10 clock = ~clock;

   ecg_r_peak_detector uut (
      .clock, .reset, .req_valid, .req_ready, .req_sample,
      .rsp_valid, .rsp_ready, .rsp_detected, .rsp_late_accept,
      .rsp_peak_value, .rsp_rr_interval
   );

   ecg_r_peak_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_sample,
      .rsp_valid, .rsp_ready, .rsp_detected, .rsp_late_accept,
      .rsp_peak_value, .rsp_rr_interval,
      .fail_count, .beats_pending, .beat_count, .late_count, .noise_count
   );

   // send one sample word; called at a falling edge, returns at one
   task automatic send_word(input logic signed [SW-1:0] s);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid  = 1;
      req_sample = s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_ready = 0;
            repeat (400) @(negedge clock);
            hold_req = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready = 0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end else begin
            rsp_ready = 1;
            @(negedge clock);
         end
      end
   end

   // watchdog
   initial begin
      #30ms;
      $display("tb_ecg_r_peak_detector failed");
      $finish;
   end

   initial begin
      logic signed [SW-1:0] directed [24];
      int spacing, wait_cycles;
      repeat (9) @(negedge clock);
      reset = 0;

      // corners: extremes, plateaus, negative peaks, alternating bits
      directed = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sh8000,
                   -16'sd5, 16'sh8000, 16'sh5555, -16'sh5556, 16'sd100, 16'sd100,
                   16'sd50, 16'sh2AAA, 16'sd0, 16'sd3000, 16'sd0, 16'sd0,
                   16'sd2000, 16'sd10, -16'sd1, 16'sd0, -16'sd1, 16'sd0};
      foreach (directed[i]) send_word(directed[i]);

      // synthetic ECG: baseline noise, spikes at random beat spacing
      while (words_sent < ITEMS) begin
         if (words_sent > 640) quiet = 1;
         if (words_sent >= 300 && !hold_started) begin
            hold_req     = 1;
            hold_started = 1;
         end
         if (words_sent >= 500 && !drain_done) begin
            req_valid = 0;
            while (beats_pending != 0) @(negedge clock);
            drain_done = 1;
         end
         spacing = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 420)
                                               : $urandom_range(100, 260);
         for (int k = 0; k < spacing - 1 && words_sent < ITEMS - 1; k++) begin
            if ($urandom_range(0, 19) == 0) send_word(SW'($urandom));
            else send_word(SW'($urandom_range(0, 300)));
         end
         if ($urandom_range(0, 9) == 0) send_word(SW'(-int'($urandom_range(1, 32768))));
         else send_word(SW'($urandom_range(2500, 32767)));
      end

      // drain and let the pipeline settle
      @(negedge clock);
      req_valid = 0;
      wait_cycles = 0;
      while (beats_pending != 0 && wait_cycles < 100000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (200) @(negedge clock);

      $display("run: %0d sample words, %0d regular beats, %0d late accepts, %0d noise peaks",
               words_sent, beat_count, late_count, noise_count);
      $display("run: included extreme samples, long result hold-off and a drain pause");
      if (fail_count == 0 && beats_pending == 0) begin
         $display("tb_ecg_r_peak_detector passed");
      end else begin
         $display("tb_ecg_r_peak_detector failed");
      end
      $finish;
   end

endmodule
